### src/sqlm_pkg.sv
// ----------------------------------------------------------------------------
// sqlm_pkg
// Shared types and constants of the LIKE pattern matcher.
// ----------------------------------------------------------------------------
package sqlm_pkg;

	typedef enum logic [1:0] {
		ACT_CLEAR  = 2'd0,
		ACT_APPEND = 2'd1,
		ACT_TEXT   = 2'd2,
		ACT_EMPTY  = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		KIND_LIT = 2'd0,
		KIND_ONE = 2'd1,
		KIND_RUN = 2'd2
	} kind_t;

	typedef struct packed {
		action_t    action;
		logic [7:0] data_byte;
		logic       last;
	} item_t;

	localparam logic [7:0] BYTE_PCT   = 8'h25;
	localparam logic [7:0] BYTE_USC   = 8'h5F;
	localparam logic [7:0] ESC_RESET  = 8'h5C;

	function automatic kind_t kind_of(input logic [7:0] b);
		kind_t k;
		if (b == BYTE_PCT) begin
			k = KIND_RUN;
		end else if (b == BYTE_USC) begin
			k = KIND_ONE;
		end else begin
			k = KIND_LIT;
		end
		return k;
	endfunction

endpackage

### src/sqlm_pattern.sv
// ----------------------------------------------------------------------------
// sqlm_pattern
// Pattern store: resolves escapes on load, up to two positions per word,
// and tracks count and overflow.
// ----------------------------------------------------------------------------
module sqlm_pattern import sqlm_pkg::*; #(
	parameter int MAX_PATTERN = 32,
	localparam int CW = $clog2(MAX_PATTERN + 1)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        fire,
	input  item_t                       item,
	input  logic [7:0]                  escape_byte,
	input  logic                        text_busy,
	output logic [MAX_PATTERN-1:0][7:0] bytes_d,
	output kind_t [MAX_PATTERN-1:0]     kinds_d,
	output logic [CW-1:0]               count_d,
	output logic                        overflow_d
);

	logic [MAX_PATTERN-1:0][7:0] bytes_q;
	kind_t [MAX_PATTERN-1:0]     kinds_q;
	logic [CW-1:0]               count_q;
	logic                        pending_q, pending_d;
	logic                        overflow_q;

	logic [7:0] st0_byte, st1_byte;
	kind_t      st0_kind, st1_kind;
	logic [1:0] n_st;
	logic [CW:0] sum;
	logic [CW:0] slot0, slot1;

	wire esc_hit = (item.data_byte == escape_byte);
	wire special = esc_hit || (item.data_byte == BYTE_USC) || (item.data_byte == BYTE_PCT);

	always_comb begin
		st0_byte  = item.data_byte;
		st0_kind  = kind_of(item.data_byte);
		st1_byte  = item.data_byte;
		st1_kind  = kind_of(item.data_byte);
		n_st      = 2'd0;
		pending_d = pending_q;
		case (item.action)
			ACT_CLEAR: begin
				pending_d = 1'b0;
			end
			ACT_APPEND: begin
				pending_d = 1'b0;
				if (pending_q) begin
					if (special) begin
						st0_kind = KIND_LIT;
						n_st     = 2'd1;
					end else begin
						st0_byte = escape_byte;
						st0_kind = kind_of(escape_byte);
						n_st     = 2'd2;
					end
				end else if (esc_hit) begin
					if (item.last) begin
						n_st = 2'd1;
					end else begin
						pending_d = 1'b1;
					end
				end else begin
					n_st = 2'd1;
				end
			end
			ACT_TEXT, ACT_EMPTY: begin
				// a pending escape is flushed as a plain byte when text starts
				if (pending_q && !(item.action == ACT_TEXT && text_busy)) begin
					st0_byte  = escape_byte;
					st0_kind  = kind_of(escape_byte);
					n_st      = 2'd1;
					pending_d = 1'b0;
				end
			end
			default: begin
				pending_d = pending_q;
			end
		endcase
	end

	assign sum   = {1'b0, count_q} + (CW + 1)'(n_st);
	assign slot0 = {1'b0, count_q};
	assign slot1 = {1'b0, count_q} + (CW + 1)'(1);

	always_comb begin
		if (item.action == ACT_CLEAR) begin
			count_d    = '0;
			overflow_d = 1'b0;
		end else if (sum > (CW + 1)'(MAX_PATTERN)) begin
			count_d    = CW'(MAX_PATTERN);
			overflow_d = 1'b1;
		end else begin
			count_d    = sum[CW-1:0];
			overflow_d = overflow_q;
		end
	end

	always_comb begin
		for (int i = 0; i < MAX_PATTERN; i++) begin
			bytes_d[i] = bytes_q[i];
			kinds_d[i] = kinds_q[i];
			if (n_st != 2'd0 && (CW + 1)'(i) == slot0) begin
				bytes_d[i] = st0_byte;
				kinds_d[i] = st0_kind;
			end
			if (n_st == 2'd2 && (CW + 1)'(i) == slot1) begin
				bytes_d[i] = st1_byte;
				kinds_d[i] = st1_kind;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			bytes_q <= bytes_d;
			kinds_q <= kinds_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			pending_q  <= 1'b0;
			overflow_q <= 1'b0;
		end else if (fire) begin
			count_q    <= count_d;
			pending_q  <= pending_d;
			overflow_q <= overflow_d;
		end
	end

endmodule

### src/sqlm_nfa.sv
// ----------------------------------------------------------------------------
// sqlm_nfa
// Active-position set: advances every position per text word and applies
// the percent closure as a log-depth prefix.
// ----------------------------------------------------------------------------
module sqlm_nfa import sqlm_pkg::*; #(
	parameter int MAX_PATTERN = 32,
	localparam int CW = $clog2(MAX_PATTERN + 1),
	localparam int N1 = MAX_PATTERN + 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        fire,
	input  item_t                       item,
	input  logic [MAX_PATTERN-1:0][7:0] bytes_d,
	input  kind_t [MAX_PATTERN-1:0]     kinds_d,
	input  logic [CW-1:0]               count_d,
	input  logic                        overflow_d,
	output logic                        matched,
	output logic                        text_busy
);

	logic [N1-1:0]          active_q;
	logic                   text_q;
	logic [MAX_PATTERN-1:0] run, step;
	logic [N1-1:0]          prop, start, base, nx, adv, res_vec;

	// position j inherits from j-1 when j-1 is a percent
	function automatic logic [N1-1:0] closure(input logic [N1-1:0] g_in,
	                                          input logic [N1-1:0] p_in);
		logic [N1-1:0] g, p, g_nx, p_nx;
		g = g_in;
		p = p_in;
		for (int d = 1; d < N1; d = d * 2) begin
			for (int j = 0; j < N1; j++) begin
				if (j >= d) begin
					g_nx[j] = g[j] | (p[j] & g[j-d]);
					p_nx[j] = p[j] & p[j-d];
				end else begin
					g_nx[j] = g[j];
					p_nx[j] = 1'b0;
				end
			end
			g = g_nx;
			p = p_nx;
		end
		return g;
	endfunction

	always_comb begin
		for (int i = 0; i < MAX_PATTERN; i++) begin
			logic in_pat;
			in_pat  = CW'(i) < count_d;
			run[i]  = in_pat && (kinds_d[i] == KIND_RUN);
			step[i] = in_pat && (kinds_d[i] != KIND_RUN)
			          && ((kinds_d[i] == KIND_ONE) || (bytes_d[i] == item.data_byte));
		end
	end

	assign prop    = {run, 1'b0};
	assign start   = closure(N1'(1), prop);
	assign base    = text_q ? active_q : start;
	assign nx      = {1'b0, base[MAX_PATTERN-1:0] & run}
	               | {base[MAX_PATTERN-1:0] & step, 1'b0};
	assign adv     = closure(nx, prop);
	assign res_vec = (item.action == ACT_TEXT) ? adv : start;
	assign matched = res_vec[count_d] && !overflow_d;
	assign text_busy = text_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= N1'(1);
			text_q   <= 1'b0;
		end else if (fire) begin
			case (item.action)
				ACT_TEXT: begin
					active_q <= adv;
					text_q   <= !item.last;
				end
				default: begin
					text_q <= 1'b0;
				end
			endcase
		end
	end

endmodule

### src/sql_like_wildcard_matcher.sv
// ----------------------------------------------------------------------------
// sql_like_wildcard_matcher
// Streaming SQL LIKE matcher with configurable escape byte.
// ----------------------------------------------------------------------------
// Input stream s_*: s_tuser carries the action (clear, append pattern byte,
// text byte, empty text), s_tdata the byte, s_tlast the final pattern or
// text byte. A clear word resets the pattern; pattern bytes follow, then any
// number of texts. Each final text byte or empty-text word yields one result
// word on m_*: m_tdata[0] matched, m_tdata[1] pattern overflow.
// Other words give no result.
// Timing: a word is registered on acceptance and processed from that
// register, its result registered in the result register that drives
// m_tvalid. One word per cycle is sustained while results are taken; the
// path is the pattern store update followed by two closure prefixes over
// MAX_PATTERN+1 positions.
// Reset: empty pattern, no escape pending, escape byte 0x5C.
// When the receiver stalls, the result is held and the input stage keeps
// taking words until a second result would be needed.
// The APB port writes and reads the escape byte at address 0.
// ----------------------------------------------------------------------------
module sql_like_wildcard_matcher import sqlm_pkg::*; #(
	parameter int MAX_PATTERN = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic [1:0]  s_tuser,   // [1:0] action
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [0] matched, [1] pattern_overflow, [7:2] zero
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int CW = $clog2(MAX_PATTERN + 1);
	localparam logic REG_ESCAPE = 1'b0;

	logic [7:0] escape_q;
	item_t      item_s1;
	logic       valid_s1;
	logic       out_valid_q;
	logic [1:0] out_data_q;
	logic       needs_result, s1_go;

	logic [MAX_PATTERN-1:0][7:0] bytes_d;
	kind_t [MAX_PATTERN-1:0]     kinds_d;
	logic [CW-1:0]               count_d;
	logic                        overflow_d;
	logic                        matched, text_busy;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_ESCAPE) ? {24'd0, escape_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			escape_q <= ESC_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_ESCAPE) begin
			escape_q <= pwdata[7:0];
		end
	end

	assign needs_result = ((item_s1.action == ACT_TEXT) && item_s1.last)
	                    || (item_s1.action == ACT_EMPTY);
	assign s1_go    = valid_s1 && (!needs_result || !out_valid_q || m_tready);
	assign s_tready = !valid_s1 || s1_go;

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1 <= '{action: action_t'(s_tuser), data_byte: s_tdata, last: s_tlast};
		end
		if (s1_go && needs_result) begin
			out_data_q <= {overflow_d, matched};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				valid_s1 <= 1'b1;
			end else if (s1_go) begin
				valid_s1 <= 1'b0;
			end
			if (s1_go && needs_result) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'd0, out_data_q};

	sqlm_pattern #(.MAX_PATTERN(MAX_PATTERN)) u_pattern (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (s1_go),
		.item        (item_s1),
		.escape_byte (escape_q),
		.text_busy   (text_busy),
		.bytes_d     (bytes_d),
		.kinds_d     (kinds_d),
		.count_d     (count_d),
		.overflow_d  (overflow_d)
	);

	sqlm_nfa #(.MAX_PATTERN(MAX_PATTERN)) u_nfa (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (s1_go),
		.item       (item_s1),
		.bytes_d    (bytes_d),
		.kinds_d    (kinds_d),
		.count_d    (count_d),
		.overflow_d (overflow_d),
		.matched    (matched),
		.text_busy  (text_busy)
	);

	a_ovf_no_match: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[1] |-> !m_tdata[0])
		else $error("match reported with overflowed pattern");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> valid_s1 && out_valid_q && !m_tready)
		else $error("input stalled without a blocked result");

	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		s1_go && needs_result |=> out_valid_q)
		else $error("result word lost");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_d <= CW'(MAX_PATTERN))
		else $error("pattern count beyond capacity");

endmodule

### tb/sql_like_wildcard_matcher_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sql_like_wildcard_matcher_test
// Self-checking bench for the streaming LIKE matcher. Pattern and text words
// are driven on s_*, and each one is run through a local copy of the pattern
// store and of the active-position set. The expected verdict goes into a
// queue and is checked against every m_* word as it is taken. Directed tests
// cover escapes, an empty pattern, abandoned texts, a full and an overflowed
// store, and escape register changes. Backpressure is tested, and then
// random pattern/text sequences with noise run while the escape register
// is moved through its extremes.
// ----------------------------------------------------------------------------
module sql_like_wildcard_matcher_test;
	import sqlm_pkg::*;

	localparam int         MAX_PAT      = 32;
	localparam int         GAP_MAX      = 8;
	localparam int         SETTLE       = 4;
	localparam int         HOLD_LONG    = 150;
	localparam int         STALL_LIMIT  = 3000;
	localparam int         RANDOM_WORDS = 630;
	localparam logic [2:0] ADDR_ESCAPE  = 3'd0;

	typedef struct packed {
		logic matched;
		logic overflow;
	} verdict_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata  = '0;    // [7:0] data_byte
	logic [1:0]  s_tuser  = '0;    // [1:0] action
	logic        s_tlast  = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;          // [0] matched, [1] pattern_overflow
	logic        psel     = 1'b0;
	logic        penable  = 1'b0;
	logic        pwrite   = 1'b0;
	logic [2:0]  paddr    = '0;
	logic [31:0] pwdata   = '0;
	logic [31:0] prdata;
	logic        pready;

	// local copy of the matcher state
	logic [7:0]      escape_reg;
	logic [7:0]      pattern_byte [MAX_PAT];
	kind_t           pattern_kind [MAX_PAT];
	int              pat_count;
	logic            escape_waiting;
	logic            overflowed;
	logic            in_text;
	logic [MAX_PAT:0] live;

	verdict_t verdict_q[$];
	int       fail_count   = 0;
	int       words_sent   = 0;
	int       hold_req     = 0;
	bit       calm         = 1'b0;
	int       stall_cycles = 0;

	always #2 clk = ~clk;

	sql_like_wildcard_matcher #(
		.MAX_PATTERN(MAX_PAT)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	function automatic void report(string what, logic [31:0] exp, logic [31:0] got);
		fail_count++;
		if (fail_count <= 10) begin
			$display("%0t mismatch on %s: expected %0h, got %0h", $realtime, what, exp, got);
		end
	endfunction

	// ---------------- pattern store and position set ----------------

	function automatic void add_position(logic [7:0] b, kind_t k);
		if (pat_count >= MAX_PAT) begin
			overflowed = 1'b1;
		end else begin
			pattern_byte[pat_count] = b;
			pattern_kind[pat_count] = k;
			pat_count++;
		end
	endfunction

	function automatic void add_plain(logic [7:0] b);
		if (b == BYTE_PCT) begin
			add_position(b, KIND_RUN);
		end else if (b == BYTE_USC) begin
			add_position(b, KIND_ONE);
		end else begin
			add_position(b, KIND_LIT);
		end
	endfunction

	function automatic void flush_escape();
		if (escape_waiting) begin
			escape_waiting = 1'b0;
			add_plain(escape_reg);
		end
	endfunction

	function automatic void load_pattern_byte(logic [7:0] b, logic l);
		bit fresh;
		fresh = 1'b1;
		if (escape_waiting) begin
			escape_waiting = 1'b0;
			if (b == escape_reg || b == BYTE_USC || b == BYTE_PCT) begin
				add_position(b, KIND_LIT);
				fresh = 1'b0;
			end else begin
				add_plain(escape_reg);
			end
		end
		if (fresh) begin
			if (b == escape_reg) begin
				escape_waiting = 1'b1;
			end else begin
				add_plain(b);
			end
		end
		if (l) begin
			flush_escape();
		end
	endfunction

	// '%' positions also enable the position after them
	function automatic void close_runs();
		for (int i = 0; i < pat_count; i++) begin
			if (live[i] && pattern_kind[i] == KIND_RUN) begin
				live[i + 1] = 1'b1;
			end
		end
	endfunction

	function automatic void restart_live();
		live    = '0;
		live[0] = 1'b1;
		close_runs();
	endfunction

	function automatic void step_live(logic [7:0] b);
		logic [MAX_PAT:0] nx;
		nx = '0;
		for (int i = 0; i < pat_count; i++) begin
			if (live[i]) begin
				if (pattern_kind[i] == KIND_RUN) begin
					nx[i] = 1'b1;
				end else if (pattern_kind[i] == KIND_ONE || pattern_byte[i] == b) begin
					nx[i + 1] = 1'b1;
				end
			end
		end
		live = nx;
		close_runs();
	endfunction

	function automatic void push_verdict();
		verdict_t v;
		v.matched  = live[pat_count] && !overflowed;
		v.overflow = overflowed;
		verdict_q.push_back(v);
		in_text = 1'b0;
	endfunction

	function automatic void predict_word(action_t act, logic [7:0] b, logic l);
		case (act)
			ACT_CLEAR: begin
				pat_count      = 0;
				escape_waiting = 1'b0;
				overflowed     = 1'b0;
				in_text        = 1'b0;
				restart_live();
			end
			ACT_APPEND: begin
				load_pattern_byte(b, l);
				in_text = 1'b0;
			end
			ACT_TEXT: begin
				if (!in_text) begin
					flush_escape();
					restart_live();
				end
				step_live(b);
				if (l) begin
					push_verdict();
				end else begin
					in_text = 1'b1;
				end
			end
			default: begin
				flush_escape();
				restart_live();
				push_verdict();
			end
		endcase
	endfunction

	// ---------------- drivers ----------------

	task automatic send_word(action_t act, logic [7:0] b, logic l);
		int gap;
		gap = calm ? 0 : $urandom_range(0, GAP_MAX);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= act;
		s_tdata  <= b;
		s_tlast  <= l;
		do @(posedge clk); while (!s_tready);
		predict_word(act, b, l);
		words_sent++;
	endtask

	// sender pauses until every verdict is back and the block has settled
	task automatic wait_quiet();
		s_tvalid <= 1'b0;
		while (verdict_q.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// write the escape byte, then read it back in a back-to-back transfer
	task automatic set_escape(logic [7:0] v);
		wait_quiet();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_ESCAPE;
		pwdata  <= {24'd0, v};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		escape_reg = v;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== {24'd0, v}) begin
			report("escape_byte readback", {24'd0, v}, prdata);
		end
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	function automatic logic [7:0] text_byte();
		logic [7:0] b;
		if ($urandom_range(0, 1) == 0) begin
			b = 8'h61 + 8'($urandom_range(0, 1));
		end else begin
			b = 8'($urandom_range(0, 255));
		end
		return b;
	endfunction

	function automatic logic [7:0] pattern_pick();
		logic [7:0] b;
		case ($urandom_range(0, 7))
			0, 1:    b = 8'h61 + 8'($urandom_range(0, 1));
			2:       b = BYTE_PCT;
			3:       b = BYTE_USC;
			4:       b = escape_reg;
			default: b = 8'($urandom_range(0, 255));
		endcase
		return b;
	endfunction

	task automatic load_pattern(int n, bit flag_last);
		send_word(ACT_CLEAR, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
		for (int i = 0; i < n; i++) begin
			send_word(ACT_APPEND, pattern_pick(), flag_last && i == n - 1);
		end
	endtask

	// builds a text that fits the loaded pattern, optionally damaged
	task automatic run_text(bit exact);
		logic [7:0] txt[$];
		kind_t      ek;
		for (int i = 0; i < pat_count; i++) begin
			case (pattern_kind[i])
				KIND_LIT: txt.push_back(pattern_byte[i]);
				KIND_ONE: txt.push_back(text_byte());
				default:  repeat ($urandom_range(0, 3)) txt.push_back(text_byte());
			endcase
		end
		if (escape_waiting && !in_text && pat_count < MAX_PAT) begin
			ek = (escape_reg == BYTE_PCT) ? KIND_RUN :
			     (escape_reg == BYTE_USC) ? KIND_ONE : KIND_LIT;
			if (ek == KIND_LIT) begin
				txt.push_back(escape_reg);
			end else if (ek == KIND_ONE) begin
				txt.push_back(text_byte());
			end
		end
		if (!exact) begin
			case ($urandom_range(0, 2))
				0: if (txt.size() > 0) txt[$urandom_range(0, txt.size() - 1)] = text_byte();
				1: if (txt.size() > 0) txt.delete($urandom_range(0, txt.size() - 1));
				default: txt.insert($urandom_range(0, txt.size()), text_byte());
			endcase
		end
		if (txt.size() == 0) begin
			send_word(ACT_EMPTY, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
		end else begin
			foreach (txt[i]) begin
				send_word(ACT_TEXT, txt[i], i == txt.size() - 1);
			end
		end
	endtask

	// ---------------- result checker ----------------

	initial begin
		int       gap;
		verdict_t exp;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			gap = calm ? 0 : $urandom_range(0, GAP_MAX);
			if (hold_req > 0) begin
				gap      = hold_req;
				hold_req = 0;
			end
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			if (verdict_q.size() == 0) begin
				fail_count++;
				if (fail_count <= 10) begin
					$display("%0t result word %0h with none expected", $realtime, m_tdata);
				end
			end else begin
				exp = verdict_q.pop_front();
				if (m_tdata[0] !== exp.matched) begin
					report("matched", exp.matched, m_tdata[0]);
				end
				if (m_tdata[1] !== exp.overflow) begin
					report("pattern_overflow", exp.overflow, m_tdata[1]);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
		if (stall_cycles >= STALL_LIMIT) begin
			$display("[sql_like_wildcard_matcher] ERROR");
			$finish;
		end
	end

	// ---------------- tests ----------------

	task automatic test_empty_pattern();
		send_word(ACT_EMPTY, 8'hFF, 1'b1);
		send_word(ACT_TEXT, 8'h00, 1'b1);
		send_word(ACT_EMPTY, 8'h00, 1'b0);
	endtask

	// escape pairs, lone escape, '%', '_' and an escape flushed by the last flag
	task automatic test_escapes();
		logic [7:0] pat [8] = '{8'h5C, BYTE_PCT, 8'h5C, 8'h71, BYTE_PCT, 8'h5C, BYTE_USC, 8'h5C};
		logic [7:0] txt [5] = '{BYTE_PCT, 8'h5C, 8'h71, BYTE_USC, 8'h5C};
		send_word(ACT_CLEAR, 8'h00, 1'b1);
		foreach (pat[i]) send_word(ACT_APPEND, pat[i], i == 7);
		foreach (txt[i]) send_word(ACT_TEXT, txt[i], i == 4);
		// text starts while an escape is pending
		send_word(ACT_APPEND, 8'h5C, 1'b0);
		send_word(ACT_EMPTY, 8'h00, 1'b0);
	endtask

	task automatic test_abandoned_text();
		send_word(ACT_TEXT, 8'h5C, 1'b0);
		send_word(ACT_APPEND, BYTE_USC, 1'b1);
		send_word(ACT_TEXT, 8'hFF, 1'b1);
	endtask

	task automatic test_full_and_overflow();
		send_word(ACT_CLEAR, 8'h00, 1'b0);
		repeat (MAX_PAT) send_word(ACT_APPEND, BYTE_PCT, 1'b0);
		send_word(ACT_TEXT, 8'h7A, 1'b1);
		send_word(ACT_APPEND, 8'h78, 1'b1);
		send_word(ACT_EMPTY, 8'h00, 1'b1);
		send_word(ACT_TEXT, 8'h78, 1'b1);
		send_word(ACT_CLEAR, 8'hFF, 1'b0);
		send_word(ACT_EMPTY, 8'h00, 1'b1);
	endtask

	task automatic test_escape_register();
		// escape pending across a register change
		send_word(ACT_CLEAR, 8'h00, 1'b0);
		send_word(ACT_APPEND, ESC_RESET, 1'b0);
		set_escape(8'hFF);
		send_word(ACT_APPEND, 8'hFF, 1'b0);
		send_word(ACT_TEXT, 8'hFF, 1'b1);
		// '%' as escape byte
		set_escape(BYTE_PCT);
		send_word(ACT_CLEAR, 8'h00, 1'b0);
		send_word(ACT_APPEND, BYTE_PCT, 1'b0);
		send_word(ACT_APPEND, BYTE_PCT, 1'b0);
		send_word(ACT_APPEND, BYTE_PCT, 1'b0);
		send_word(ACT_APPEND, 8'h61, 1'b0);
		send_word(ACT_APPEND, BYTE_PCT, 1'b1);
		send_word(ACT_TEXT, BYTE_PCT, 1'b0);
		send_word(ACT_TEXT, 8'h7A, 1'b0);
		send_word(ACT_TEXT, 8'h61, 1'b1);
		set_escape(8'h00);
		send_word(ACT_CLEAR, 8'h00, 1'b0);
		send_word(ACT_APPEND, 8'h00, 1'b0);
		send_word(ACT_APPEND, 8'h00, 1'b0);
		send_word(ACT_APPEND, 8'h00, 1'b1);
		send_word(ACT_TEXT, 8'h00, 1'b0);
		send_word(ACT_TEXT, 8'h00, 1'b1);
		set_escape(ESC_RESET);
	endtask

	// receiver holds off while the sender keeps offering results
	task automatic test_backpressure();
		send_word(ACT_CLEAR, 8'h00, 1'b0);
		send_word(ACT_APPEND, BYTE_PCT, 1'b1);
		hold_req = HOLD_LONG;
		calm     = 1'b1;
		repeat (30) send_word(ACT_TEXT, text_byte(), 1'($urandom_range(0, 3) != 0));
		calm = 1'b0;
		wait_quiet();
	endtask

	task automatic test_random_traffic();
		int         start;
		int         scen;
		int         n;
		logic [7:0] esc;
		start = words_sent;
		scen  = 0;
		while (words_sent - start < RANDOM_WORDS) begin
			if (scen % 10 == 9) begin
				case ($urandom_range(0, 5))
					0:       esc = 8'h00;
					1:       esc = 8'hFF;
					2:       esc = ESC_RESET;
					3:       esc = BYTE_PCT;
					4:       esc = BYTE_USC;
					default: esc = 8'($urandom_range(0, 255));
				endcase
				set_escape(esc);
			end
			calm = ($urandom_range(0, 4) == 0);
			case ($urandom_range(0, 9))
				0: begin
					repeat ($urandom_range(4, 12)) begin
						send_word(action_t'($urandom_range(0, 3)), pattern_pick(),
							1'($urandom_range(0, 1)));
					end
				end
				1: begin
					repeat ($urandom_range(1, 3)) send_word(ACT_TEXT, text_byte(), 1'b0);
					send_word(ACT_APPEND, pattern_pick(), 1'($urandom_range(0, 1)));
					run_text(1'($urandom_range(0, 1)));
				end
				default: begin
					n = ($urandom_range(0, 9) == 0) ? $urandom_range(28, 36) : $urandom_range(0, 8);
					load_pattern(n, $urandom_range(0, 4) != 0);
					repeat ($urandom_range(1, 4)) run_text(1'($urandom_range(0, 1)));
				end
			endcase
			scen++;
		end
		calm = 1'b0;
	endtask

	initial begin
		escape_reg     = ESC_RESET;
		pat_count      = 0;
		escape_waiting = 1'b0;
		overflowed     = 1'b0;
		in_text        = 1'b0;
		restart_live();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_pattern();
		test_escapes();
		test_abandoned_text();
		test_full_and_overflow();
		test_escape_register();
		test_backpressure();
		test_random_traffic();
		wait_quiet();
		if (fail_count == 0) begin
			$display("[sql_like_wildcard_matcher] OK");
		end else begin
			$display("[sql_like_wildcard_matcher] ERROR");
		end
		$finish;
	end

endmodule
